FILE: rtl/core/satt_pkg.sv
// Package: constants, types and helpers of the set-associative transposition table.
package satt_pkg;

   localparam int MaxClusters   = 1024;
   localparam int Ways          = 3;
   localparam int KeyBits       = 16;
   localparam int ClusterBits   = 10;
   localparam int WayBits       = 2;
   localparam int GenBits       = 5;
   localparam int CountBits     = 11;
   localparam int AddrBits      = 2;
   localparam logic [15:0] ValueNone = 16'd32002;
   localparam logic [CountBits-1:0] CountReset = 11'd1024;

   typedef enum logic [1:0] {
      OP_PROBE = 2'd0,
      OP_SAVE  = 2'd1,
      OP_NEW   = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_OUT
   } state_type;

   localparam logic [AddrBits-1:0] RegClusterCount = 2'd0;

   // one stored entry: key, depth, pv, bound, gen, move, score, eval
   typedef struct packed {
      logic [KeyBits-1:0] key;
      logic [7:0]         depth;
      logic               pv;
      logic [1:0]         bound;
      logic [GenBits-1:0] gen;
      logic [15:0]        move;
      logic [15:0]        score;
      logic [15:0]        eval;
   } entry_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [63:0]            position_key;
      logic                   side_flag;
      logic [ClusterBits-1:0] slot_cluster;
      logic [WayBits-1:0]     slot_way;
      logic signed [15:0]     score_in;
      logic signed [15:0]     static_eval_in;
      logic [7:0]             depth_in;
      logic [1:0]             bound_in;
      logic                   pv_in;
      logic [15:0]            best_move_in;
      logic [GenBits-1:0]     save_generation;
   } req_type;

   typedef struct packed {
      logic                   hit;
      logic [ClusterBits-1:0] found_cluster;
      logic [WayBits-1:0]     found_way;
      logic signed [15:0]     score_out;
      logic signed [15:0]     static_eval_out;
      logic [7:0]             depth_out;
      logic [1:0]             bound_out;
      logic                   pv_out;
      logic [15:0]            best_move_out;
      logic [GenBits-1:0]     current_generation;
   } rsp_type;

   // replacement worth: depth minus 8 times age
   function automatic logic signed [9:0] worth(input entry_type e,
                                               input logic [GenBits-1:0] g);
      logic [GenBits-1:0] age;
      age = g - e.gen;
      return $signed({2'b00, e.depth}) - $signed({2'b00, age, 3'b000});
   endfunction

endpackage

FILE: rtl/core/satt_if.sv
// Interfaces: valid/ready transaction channels for requests and responses.
interface satt_req_if;
   logic                 valid;
   logic                 ready;
   satt_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface satt_rsp_if;
   logic                 valid;
   logic                 ready;
   satt_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/satt_cluster_ram.sv
// Cluster memory: one row holds all ways of a cluster, registered read.
module satt_cluster_ram (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [satt_pkg::ClusterBits-1:0]            wr_addr,
   input  satt_pkg::entry_type [satt_pkg::Ways-1:0]    wr_data,
   input  logic [satt_pkg::ClusterBits-1:0]            rd_addr,
   output satt_pkg::entry_type [satt_pkg::Ways-1:0]    rd_data
);
   satt_pkg::entry_type [satt_pkg::Ways-1:0] mem [satt_pkg::MaxClusters];

   // write one row, read one row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/core/set_assoc_transposition_table_unit.sv
// Top level: set-associative transposition table with probe, save, new search and clear.
// A transaction runs through the states IDLE, LOOK and OUT. The accepting cycle issues the
// read of the cluster row. The next cycle compares the ways, chooses a victim or merges a
// save, and writes the row back. In OUT the response sits in its output register until it
// is taken, and a new request is taken once the response has left. Saves use the single
// cluster memory for one read and one write; probes only read it. After reset and after a
// clear, a pass writes zero to all 1024 cluster rows, one per cycle, and no request is
// accepted meanwhile.
module set_assoc_transposition_table_unit (
   input  logic               clock,
   input  logic               reset,
   satt_req_if.sink           req,
   satt_rsp_if.source         rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [satt_pkg::AddrBits-1:0] csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int CB = satt_pkg::ClusterBits;
   localparam int GB = satt_pkg::GenBits;

   satt_pkg::state_type state_ff, state_in;
   logic [CB-1:0]       clr_ff, clr_in;
   logic [GB-1:0]       gen_ff, gen_in;
   logic [satt_pkg::CountBits-1:0] count_ff;
   satt_pkg::req_type   req_ff;
   satt_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CB-1:0]       cl_ff, cl_in;

   satt_pkg::entry_type [satt_pkg::Ways-1:0] row_rd, row_wr;
   logic          wr_en;
   logic [CB-1:0] wr_addr, rd_addr;

   logic csr_wr;
   logic [satt_pkg::CountBits-1:0] eff;
   logic [74:0] prod;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == satt_pkg::RegClusterCount) begin
         csr_prdata = {21'd0, count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= satt_pkg::CountReset;
      end else if (csr_wr && csr_paddr == satt_pkg::RegClusterCount) begin
         count_ff <= csr_pwdata[satt_pkg::CountBits-1:0];
      end
   end

   // effective cluster count and cluster index from the high product
   always_comb begin
      eff = count_ff;
      if (eff > satt_pkg::CountBits'(satt_pkg::MaxClusters)) begin
         eff = satt_pkg::CountBits'(satt_pkg::MaxClusters);
      end
      eff[0] = 1'b0;
      if (eff < 11'd2) begin
         eff = 11'd2;
      end
      prod = req.data.position_key * eff;
      cl_in = {prod[64+CB-1:65], req.data.side_flag};
   end

   satt_cluster_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (row_wr),
      .rd_addr (rd_addr),
      .rd_data (row_rd)
   );

   assign req.ready = (state_ff == satt_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == satt_pkg::ST_OUT);
   assign rsp.data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         satt_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CB'(satt_pkg::MaxClusters - 1)) begin
               state_in = satt_pkg::ST_IDLE;
            end
         end
         satt_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = satt_pkg::ST_LOOK;
            end
         end
         satt_pkg::ST_LOOK: state_in = satt_pkg::ST_OUT;
         satt_pkg::ST_OUT: begin
            if (rsp.ready) begin
               state_in = (req_ff.opcode == satt_pkg::OP_CLEAR) ?
                          satt_pkg::ST_CLEAR : satt_pkg::ST_IDLE;
            end
         end
         default: state_in = satt_pkg::ST_IDLE;
      endcase
   end

   // lookup, victim choice, save merge and response
   always_comb begin
      logic found;
      logic [satt_pkg::WayBits-1:0] way, best;
      logic signed [9:0] bv, v;
      satt_pkg::entry_type e;
      logic new_key, repl;
      logic [GB-1:0] gsave;
      found  = 1'b0;
      way    = '0;
      best   = '0;
      bv     = satt_pkg::worth(row_rd[0], gen_ff);
      row_wr = row_rd;
      wr_en  = 1'b0;
      wr_addr = cl_ff;
      rd_addr = (state_ff == satt_pkg::ST_IDLE) ?
                ((req.data.opcode == satt_pkg::OP_SAVE) ? req.data.slot_cluster : cl_in)
                : cl_ff;
      gen_in = gen_ff;
      rsp_in = rsp_ff;
      e      = row_rd[0];
      new_key = 1'b0;
      repl    = 1'b0;
      gsave   = req_ff.save_generation;
      for (int w = satt_pkg::Ways - 1; w >= 0; w--) begin
         if (row_rd[w].key == req_ff.position_key[satt_pkg::KeyBits-1:0]) begin
            found = 1'b1;
            way   = satt_pkg::WayBits'(w);
         end
      end
      for (int w = 1; w < satt_pkg::Ways; w++) begin
         v = satt_pkg::worth(row_rd[w], gen_ff);
         if (bv > v) begin
            bv   = v;
            best = satt_pkg::WayBits'(w);
         end
      end
      if (state_ff == satt_pkg::ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         row_wr  = '0;
         gen_in  = '0;
      end else if (state_ff == satt_pkg::ST_LOOK) begin
         rsp_in = '0;
         case (req_ff.opcode)
            satt_pkg::OP_PROBE: begin
               rsp_in.found_cluster = cl_ff;
               if (found) begin
                  e = row_rd[way];
                  rsp_in.hit             = (e.depth != 8'd0);
                  rsp_in.found_way       = way;
                  rsp_in.score_out       = e.score;
                  rsp_in.static_eval_out = e.eval;
                  rsp_in.depth_out       = e.depth;
                  rsp_in.bound_out       = e.bound;
                  rsp_in.pv_out          = e.pv;
                  rsp_in.best_move_out   = e.move;
               end else begin
                  rsp_in.found_way       = best;
                  rsp_in.score_out       = satt_pkg::ValueNone;
                  rsp_in.static_eval_out = satt_pkg::ValueNone;
               end
            end
            satt_pkg::OP_SAVE: begin
               rsp_in.found_cluster = req_ff.slot_cluster;
               rsp_in.found_way     = req_ff.slot_way;
               if (req_ff.slot_way < satt_pkg::WayBits'(satt_pkg::Ways)) begin
                  e = row_rd[req_ff.slot_way];
                  new_key = (e.key != req_ff.position_key[satt_pkg::KeyBits-1:0]);
                  repl = (req_ff.bound_in == 2'b11) || new_key ||
                         ($signed({3'b000, req_ff.depth_in} + {9'd0, req_ff.pv_in, 1'b0}) >
                          $signed({3'b000, e.depth}) - 11'sd4) ||
                         ((gsave - e.gen) != '0);
                  if (req_ff.best_move_in != 16'd0 || new_key) begin
                     e.move = req_ff.best_move_in;
                  end
                  if (repl) begin
                     e.key   = req_ff.position_key[satt_pkg::KeyBits-1:0];
                     e.depth = req_ff.depth_in;
                     e.pv    = req_ff.pv_in;
                     e.bound = req_ff.bound_in;
                     e.gen   = gsave;
                     e.score = req_ff.score_in;
                     e.eval  = req_ff.static_eval_in;
                  end
                  row_wr[req_ff.slot_way] = e;
                  wr_en   = 1'b1;
                  wr_addr = req_ff.slot_cluster;
               end
            end
            satt_pkg::OP_NEW: gen_in = gen_ff + 1'b1;
            default: gen_in = '0;
         endcase
         rsp_in.current_generation = gen_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= satt_pkg::ST_CLEAR;
         clr_ff   <= '0;
         gen_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         gen_ff   <= gen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_ff <= req.data;
         cl_ff  <= (req.data.opcode == satt_pkg::OP_SAVE) ? req.data.slot_cluster : cl_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule

FILE: rtl/core/satt_checker.sv
// Checker: port-level properties of the transposition table, bound to the top level.
module satt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input satt_pkg::rsp_type rsp_data
);
   // hold response while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   // no request accepted while a response is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted with response pending");
   // accepted request answers after the LOOK state
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("response late");
   // a hit always carries a nonzero depth
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.depth_out != 8'd0)
      else $error("hit with empty depth");
endmodule

bind set_assoc_transposition_table_unit satt_checker u_satt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
